// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define RDT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdt assertion failed");

// next-cycle implication, checked on clk outside reset
`define RDT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdt assertion failed");

`endif

// ----- hdl/rdt_pkg.sv -----
package rdt_pkg;

  localparam int COUNTER_WIDTH_DEF    = 24;
  localparam int PRESCALE_DIVISOR_DEF = 8;

  localparam int CMD_W  = 2;
  localparam int SEL_W  = 2;
  localparam int DATA_W = 24;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int CTRL_EN_BIT   = 0;
  localparam int CTRL_IE_BIT   = 1;
  localparam int CTRL_OS_BIT   = 2;
  localparam int CTRL_FLAG_BIT = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef enum logic [SEL_W-1:0] {
    SEL_CTRL    = 2'd0,
    SEL_RELOAD  = 2'd1,
    SEL_CURRENT = 2'd2,
    SEL_ELAPSED = 2'd3
  } sel_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SEL_W-1:0]  register_select;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              interrupt_pulse;
    logic              running;
  } result_t;

endpackage

// ----- hdl/rdt_if.sv -----
interface rdt_item_if import rdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SEL_W-1:0]  register_select;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, command, register_select, write_data, input ready);
  modport sink (input valid, command, register_select, write_data, output ready);
endinterface

interface rdt_result_if import rdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              interrupt_pulse;
  logic              running;

  modport source (output valid, read_data, interrupt_pulse, running, input ready);
  modport sink (input valid, read_data, interrupt_pulse, running, output ready);
endinterface

// ----- hdl/rdt_in_stage.sv -----
module rdt_in_stage import rdt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  rdt_item_if.sink item,
  input  logic   fire,
  output logic   full,
  output item_t  held
);

  assign item.ready = !full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item.ready) begin
      full <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held.command         <= item.command;
      held.register_select <= item.register_select;
      held.write_data      <= item.write_data;
    end
  end

endmodule

// ----- hdl/rdt_core.sv -----
module rdt_core import rdt_pkg::*; #(
  parameter int COUNTER_WIDTH    = COUNTER_WIDTH_DEF,
  parameter int PRESCALE_DIVISOR = PRESCALE_DIVISOR_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   held,
  input  logic    clock_source_direct,
  output result_t res
);

  localparam int PW = $clog2(PRESCALE_DIVISOR);

  logic                     enable_bit, enable_bit_next;
  logic                     interrupt_enable_bit, interrupt_enable_bit_next;
  logic                     one_shot_bit, one_shot_bit_next;
  logic                     count_flag, count_flag_next;
  logic [COUNTER_WIDTH-1:0] reload_value, reload_value_next;
  logic [COUNTER_WIDTH-1:0] current_count, current_count_next;
  logic [PW-1:0]            prescale_count, prescale_count_next;

  logic [PW:0]              prescale_inc;
  logic [COUNTER_WIDTH-1:0] count_dec;
  logic                     counted;
  cmd_t                     cmd;
  sel_t                     sel;

  assign cmd          = cmd_t'(held.command);
  assign sel          = sel_t'(held.register_select);
  assign prescale_inc = (PW + 1)'(prescale_count) + (PW + 1)'(1);
  assign count_dec    = current_count - COUNTER_WIDTH'(1);

  always_comb begin
    enable_bit_next           = enable_bit;
    interrupt_enable_bit_next = interrupt_enable_bit;
    one_shot_bit_next         = one_shot_bit;
    count_flag_next           = count_flag;
    reload_value_next         = reload_value;
    current_count_next        = current_count;
    prescale_count_next       = prescale_count;
    counted                   = 1'b0;
    res.read_data             = '0;
    res.interrupt_pulse       = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (enable_bit) begin
          if (clock_source_direct) begin
            counted = 1'b1;
          end else if (prescale_inc == (PW + 1)'(PRESCALE_DIVISOR)) begin
            counted             = 1'b1;
            prescale_count_next = '0;
          end else begin
            prescale_count_next = prescale_inc[PW-1:0];
          end
          if (counted) begin
            if (current_count == '0) begin
              current_count_next = reload_value;
            end else begin
              current_count_next = count_dec;
              if (count_dec == '0) begin
                count_flag_next     = 1'b1;
                res.interrupt_pulse = interrupt_enable_bit;
                if (one_shot_bit) begin
                  enable_bit_next   = 1'b0;
                  one_shot_bit_next = 1'b0;
                end
              end
            end
          end
        end
      end
      CMD_READ: begin
        unique case (sel)
          SEL_CTRL: begin
            res.read_data[CTRL_EN_BIT]   = enable_bit;
            res.read_data[CTRL_IE_BIT]   = interrupt_enable_bit;
            res.read_data[CTRL_OS_BIT]   = one_shot_bit;
            res.read_data[CTRL_FLAG_BIT] = count_flag;
            count_flag_next              = 1'b0;
          end
          SEL_RELOAD:  res.read_data = DATA_W'(reload_value);
          SEL_CURRENT: res.read_data = DATA_W'(current_count);
          SEL_ELAPSED: res.read_data = DATA_W'(COUNTER_WIDTH'(reload_value - current_count));
        endcase
      end
      CMD_WRITE: begin
        unique case (sel)
          SEL_CTRL: begin
            enable_bit_next           = held.write_data[CTRL_EN_BIT];
            interrupt_enable_bit_next = held.write_data[CTRL_IE_BIT];
            one_shot_bit_next         = held.write_data[CTRL_OS_BIT];
          end
          SEL_RELOAD: reload_value_next = COUNTER_WIDTH'(held.write_data);
          SEL_CURRENT: begin
            current_count_next = '0;
            count_flag_next    = 1'b0;
          end
          SEL_ELAPSED: ;
        endcase
      end
      default: ;
    endcase
    res.running = enable_bit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_bit           <= 1'b0;
      interrupt_enable_bit <= 1'b0;
      one_shot_bit         <= 1'b0;
      count_flag           <= 1'b0;
      reload_value         <= '0;
      current_count        <= '0;
      prescale_count       <= '0;
    end else if (fire) begin
      enable_bit           <= enable_bit_next;
      interrupt_enable_bit <= interrupt_enable_bit_next;
      one_shot_bit         <= one_shot_bit_next;
      count_flag           <= count_flag_next;
      reload_value         <= reload_value_next;
      current_count        <= current_count_next;
      prescale_count       <= prescale_count_next;
    end
  end

endmodule

// ----- hdl/rdt_out_stage.sv -----
module rdt_out_stage import rdt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  result_t   res,
  output logic      can_load,
  rdt_result_if.source result
);

  result_t held;

  assign can_load               = !result.valid || result.ready;
  assign result.read_data       = held.read_data;
  assign result.interrupt_pulse = held.interrupt_pulse;
  assign result.running         = held.running;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held <= res;
    end
  end

endmodule

// ----- hdl/reload_down_timer.sv -----
// an accepted word waits in the input stage, its result in the output stage
// throughput: one word per cycle, held back only when the result side stalls
// the counter state updates in the single step between input and result registers
// reset (rst, synchronous): control bits, counts and prescaler clear,
// clock source returns to direct, both stages empty
`include "assert_macros.svh"

module reload_down_timer import rdt_pkg::*; #(
  parameter int COUNTER_WIDTH    = COUNTER_WIDTH_DEF,
  parameter int PRESCALE_DIVISOR = PRESCALE_DIVISOR_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  rdt_item_if.sink              item,
  rdt_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic    full;
  logic    can_load;
  logic    fire;
  logic    cfg_wr;
  logic    clock_source_direct;
  item_t   held;
  result_t res;

  assign fire   = full && can_load;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[APB_ADDR_W-1];
  assign prdata = paddr[APB_ADDR_W-1] ? '0 : APB_DATA_W'(clock_source_direct);

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_source_direct <= 1'b1;
    end else if (cfg_wr) begin
      clock_source_direct <= pwdata[0];
    end
  end

  rdt_in_stage u_in (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .fire (fire),
    .full (full),
    .held (held)
  );

  rdt_core #(
    .COUNTER_WIDTH    (COUNTER_WIDTH),
    .PRESCALE_DIVISOR (PRESCALE_DIVISOR)
  ) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .fire                (fire),
    .held                (held),
    .clock_source_direct (clock_source_direct),
    .res                 (res)
  );

  rdt_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .res      (res),
    .can_load (can_load),
    .result   (result)
  );

  `RDT_ASSERT_IMP(a_pulse_no_data, result.valid && result.interrupt_pulse, result.read_data == '0)
  `RDT_ASSERT_IMP(a_stall_blocks_in, full && result.valid && !result.ready, !item.ready)
  `RDT_ASSERT_NXT(a_fire_loads_out, fire, result.valid)
  `RDT_ASSERT_NXT(a_cfg_write, cfg_wr, clock_source_direct == $past(pwdata[0]))

endmodule
